>>> design/cdf_pkg.sv
// Shared types and constants for the command stream deframer.
// Holds the result kinds, error codes, parse phases and the opcode class table.
// Depends on nothing else.
package cdf_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER     = 3'd0,
    KIND_LENGTH     = 3'd1,
    KIND_PAYLOAD    = 3'd2,
    KIND_TERMINATOR = 3'd3,
    KIND_ERROR      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_MISSING = 2'd1,
    ERR_UNKNOWN = 2'd2,
    ERR_OVERRUN = 2'd3
  } error_e;

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOPPED = 2'd3
  } phase_e;

  localparam logic [7:0] OP_END          = 8'h00;
  localparam logic [7:0] OP_CLASS1_BASE  = 8'h20;
  localparam logic [7:0] OP_CLASS2_BASE  = 8'h40;
  localparam logic [7:0] OP_CLASS4_BASE  = 8'h60;
  localparam logic [7:0] OP_CLASS6_BASE  = 8'h80;
  localparam logic [7:0] OP_CLASS8_BASE  = 8'ha0;
  localparam logic [7:0] OP_EXPLICIT_BASE = 8'hc0;
  localparam logic [7:0] OP_UNKNOWN_BASE = 8'he0;

  // Register addresses: bit 2 of paddr selects the register slot.
  localparam logic REG_REGION_LENGTH = 1'b0;

  // Payload length implied by the opcode class (opcodes below the explicit range).
  function automatic logic [7:0] class_length(input logic [7:0] op);
    logic [7:0] len;
    if (op < OP_CLASS1_BASE) begin
      len = 8'd0;
    end else if (op < OP_CLASS2_BASE) begin
      len = 8'd1;
    end else if (op < OP_CLASS4_BASE) begin
      len = 8'd2;
    end else if (op < OP_CLASS6_BASE) begin
      len = 8'd4;
    end else if (op < OP_CLASS8_BASE) begin
      len = 8'd6;
    end else begin
      len = 8'd8;
    end
    return len;
  endfunction

endpackage

>>> design/command_stream_deframer.sv
// Command stream deframer: top level, one byte per transaction in, one result out.
// Uses cdf_pkg for kinds, error codes, phases and the opcode class table.
//
// Usage. Bytes of a command region arrive on the input channel (in_valid_i,
// in_stall_o, data_byte_i). Each byte inside the region gives one result
// transaction on the output channel (out_valid_o, out_stall_i and the result
// fields); bytes beyond region_length, or after a terminator or an error,
// are taken and dropped. region_length is written through the APB port at
// byte address 0 while the block is idle.
// Latency: a result appears in the cycle after its byte is taken.
// Throughput: one byte per cycle unless stalled; the classification of a byte
// and the state update are a single compare-and-add stage ahead of the result
// register. Back-pressure: while a result waits with out_stall_i high, in_stall_o
// is high; as soon as the result is taken a new byte is accepted in that cycle.
// Reset: the parser returns to expecting an opcode at position zero,
// region_length clears to zero and the result register empties.
module command_stream_deframer #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  opcode_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  byte_index_o,
  output logic [7:0]  payload_byte_o,
  output logic        command_done_o,
  output logic [1:0]  error_code_o,
  output logic        region_end_o
);

  // Wide enough for position + 1 + 255 and for the 16-bit region length.
  localparam int CW = ((POSITION_WIDTH > 16) ? POSITION_WIDTH : 16) + 1;

  logic [15:0] region_length_q;

  cdf_pkg::phase_e           phase_q, phase_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [7:0]                op_q, op_d;
  logic [7:0]                len_q, len_d;
  logic [7:0]                cnt_q, cnt_d;

  logic                      out_valid_q;
  cdf_pkg::kind_e            kind_q, kind_d;
  cdf_pkg::error_e           err_q, err_d;
  logic [7:0]                res_op_q, res_op_d;
  logic [7:0]                res_len_q, res_len_d;
  logic [7:0]                res_idx_q, res_idx_d;
  logic [7:0]                res_byte_q, res_byte_d;
  logic                      res_done_q, res_done_d;
  logic                      res_end_q, res_end_d;
  logic                      res_fire;

  logic                      in_accept;
  logic [CW-1:0]             pos_ext, next_ext, reg_ext;
  logic [7:0]                cls_len;
  logic                      pay_done;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cdf_pkg::REG_REGION_LENGTH) ? {16'd0, region_length_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_length_q <= 16'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == cdf_pkg::REG_REGION_LENGTH) begin
      region_length_q <= pwdata[15:0];
    end
  end

  // Handshake: a waiting result that is stalled holds off new bytes.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pos_ext  = CW'(pos_q);
  assign next_ext = pos_ext + CW'(1);
  assign reg_ext  = CW'(region_length_q);
  assign cls_len  = cdf_pkg::class_length(data_byte_i);
  assign pay_done = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    op_d       = op_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    res_fire   = 1'b0;
    kind_d     = cdf_pkg::KIND_HEADER;
    err_d      = cdf_pkg::ERR_NONE;
    res_op_d   = 8'd0;
    res_len_d  = 8'd0;
    res_idx_d  = 8'd0;
    res_byte_d = 8'd0;
    res_done_d = 1'b0;
    res_end_d  = (next_ext == reg_ext);

    if (in_accept && phase_q != cdf_pkg::PH_STOPPED && pos_ext < reg_ext) begin
      res_fire = 1'b1;
      if (pos_q != {POSITION_WIDTH{1'b1}}) begin
        pos_d = pos_q + POSITION_WIDTH'(1);
      end
      unique case (phase_q)
        cdf_pkg::PH_OPCODE: begin
          if (data_byte_i == cdf_pkg::OP_END) begin
            phase_d = cdf_pkg::PH_STOPPED;
            kind_d  = cdf_pkg::KIND_TERMINATOR;
          end else begin
            op_d     = data_byte_i;
            res_op_d = data_byte_i;
            priority if (data_byte_i >= cdf_pkg::OP_UNKNOWN_BASE) begin
              phase_d = cdf_pkg::PH_STOPPED;
              kind_d  = cdf_pkg::KIND_ERROR;
              err_d   = cdf_pkg::ERR_UNKNOWN;
            end else if (data_byte_i >= cdf_pkg::OP_EXPLICIT_BASE) begin
              if (next_ext >= reg_ext) begin
                phase_d = cdf_pkg::PH_STOPPED;
                kind_d  = cdf_pkg::KIND_ERROR;
                err_d   = cdf_pkg::ERR_MISSING;
              end else begin
                len_d   = 8'd0;
                phase_d = cdf_pkg::PH_LENGTH;
              end
            end else if (next_ext + CW'(cls_len) > reg_ext) begin
              phase_d   = cdf_pkg::PH_STOPPED;
              kind_d    = cdf_pkg::KIND_ERROR;
              err_d     = cdf_pkg::ERR_OVERRUN;
              res_len_d = cls_len;
            end else begin
              len_d      = cls_len;
              cnt_d      = 8'd0;
              phase_d    = (cls_len == 8'd0) ? cdf_pkg::PH_OPCODE : cdf_pkg::PH_PAYLOAD;
              res_len_d  = cls_len;
              res_done_d = (cls_len == 8'd0);
            end
          end
        end
        cdf_pkg::PH_LENGTH: begin
          res_op_d  = op_q;
          res_len_d = data_byte_i;
          if (next_ext + CW'(data_byte_i) > reg_ext) begin
            phase_d = cdf_pkg::PH_STOPPED;
            kind_d  = cdf_pkg::KIND_ERROR;
            err_d   = cdf_pkg::ERR_OVERRUN;
          end else begin
            len_d      = data_byte_i;
            cnt_d      = 8'd0;
            phase_d    = (data_byte_i == 8'd0) ? cdf_pkg::PH_OPCODE : cdf_pkg::PH_PAYLOAD;
            kind_d     = cdf_pkg::KIND_LENGTH;
            res_done_d = (data_byte_i == 8'd0);
          end
        end
        cdf_pkg::PH_PAYLOAD: begin
          cnt_d      = cnt_q + 8'd1;
          kind_d     = cdf_pkg::KIND_PAYLOAD;
          res_op_d   = op_q;
          res_len_d  = len_q;
          res_idx_d  = cnt_q;
          res_byte_d = data_byte_i;
          res_done_d = pay_done;
          if (pay_done) begin
            phase_d = cdf_pkg::PH_OPCODE;
          end
        end
        cdf_pkg::PH_STOPPED: begin
          res_fire = 1'b0;
        end
        default: begin
          res_fire = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cdf_pkg::PH_OPCODE;
      pos_q       <= '0;
      op_q        <= 8'd0;
      len_q       <= 8'd0;
      cnt_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      op_q    <= op_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      if (!in_stall_o) begin
        out_valid_q <= res_fire;
      end
    end
  end

  // Result register: loaded only when a byte produces a result.
  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      kind_q     <= kind_d;
      err_q      <= err_d;
      res_op_q   <= res_op_d;
      res_len_q  <= res_len_d;
      res_idx_q  <= res_idx_d;
      res_byte_q <= res_byte_d;
      res_done_q <= res_done_d;
      res_end_q  <= res_end_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign error_code_o     = err_q;
  assign opcode_o         = res_op_q;
  assign payload_length_o = res_len_q;
  assign byte_index_o     = res_idx_q;
  assign payload_byte_o   = res_byte_q;
  assign command_done_o   = res_done_q;
  assign region_end_o     = res_end_q;

endmodule

>>> design/cdf_checker.sv
// Port-level checker for the command stream deframer and its bind statement.
// Uses cdf_pkg for the result kinds and error codes.
module cdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] payload_length_o,
  input logic [7:0] byte_index_o,
  input logic       command_done_o,
  input logic [1:0] error_code_o
);

  // A result that is stalled is still offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result was dropped");

  // The error code is set exactly on error results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == cdf_pkg::KIND_ERROR) == (error_code_o != cdf_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  // Once a terminator or an error is delivered, parsing has stopped for good.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i &&
    (kind_o == cdf_pkg::KIND_TERMINATOR || kind_o == cdf_pkg::KIND_ERROR)
    |=> !out_valid_o)
    else $error("result delivered after the stream stopped");

  // A payload byte lies inside its payload, and completes it only at the last index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == cdf_pkg::KIND_PAYLOAD |->
    byte_index_o < payload_length_o &&
    command_done_o == (({1'b0, byte_index_o} + 9'd1) == {1'b0, payload_length_o}))
    else $error("payload byte index out of place");

endmodule

bind command_stream_deframer cdf_checker u_cdf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .payload_length_o (payload_length_o),
  .byte_index_o     (byte_index_o),
  .command_done_o   (command_done_o),
  .error_code_o     (error_code_o)
);
